>>> rtl/seq_pkg.sv
`default_nettype none
package seq_pkg;
    localparam int Depth = 32;
    localparam int CntW = $clog2(Depth + 1);
    localparam int PosW = $clog2(Depth);

    typedef enum logic [2:0] {
        KIND_INSERT   = 3'd0,
        KIND_EXTRACT  = 3'd1,
        KIND_RECOVER  = 3'd2,
        KIND_LONGWAIT = 3'd3,
        KIND_MISS     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic [0:0] REG_LONG_WAIT = 1'b0;
    localparam logic [0:0] REG_MISS_WAIT = 1'b1;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] done_cycle;
        logic [31:0] sequence_num;
        logic [31:0] issue_cycle;
        logic [2:0]  thread;
        logic        is_load;
        logic        spec;
    } entry_t;

    // Command broadcast to every cell for one operation.
    typedef struct packed {
        logic        ins;
        logic        ext;
        logic        rec;
        logic        qry;
        logic        loads_only;
        logic [2:0]  thread;
        logic [31:0] now_cycle;
        logic [15:0] limit;
        entry_t      new_entry;
    } cmd_t;

    // Per-cell status toward the neighbors and the top.
    typedef struct packed {
        logic   valid;
        logic   key_after;
        logic   kill;
        logic   hit;
        entry_t data;
    } cell_out_t;
endpackage
`default_nettype wire

>>> rtl/seq_cell.sv
`default_nettype none
module seq_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire seq_pkg::cmd_t    cmd,
    input  wire logic             phase,
    input  wire logic             is_last,
    input  wire seq_pkg::cell_out_t left,
    input  wire seq_pkg::cell_out_t right,
    output seq_pkg::cell_out_t    self_out
);
    import seq_pkg::*;

    logic   valid_reg, valid_next;
    entry_t data_reg, data_next;
    logic   mark_reg, mark_next;
    logic   key_after;
    logic   kill;
    logic [31:0] wait_cycles;

    // Stored key strictly greater than the new key.
    always_comb
    begin
        if (cmd.new_entry.done_cycle != data_reg.done_cycle)
            key_after = data_reg.done_cycle > cmd.new_entry.done_cycle;
        else
            key_after = data_reg.sequence_num > cmd.new_entry.sequence_num;
    end

    assign kill = valid_reg && data_reg.spec && (data_reg.thread == cmd.thread);
    assign wait_cycles = cmd.now_cycle - data_reg.issue_cycle;

    always_comb
    begin
        self_out.valid     = valid_reg;
        self_out.key_after = valid_reg && key_after;
        self_out.kill      = mark_reg;
        self_out.hit       = valid_reg && (data_reg.thread == cmd.thread)
                             && (!cmd.loads_only || data_reg.is_load)
                             && (wait_cycles > {16'd0, cmd.limit});
        self_out.data      = data_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        mark_next  = 1'b0;
        if (cmd.ins && !phase)
        begin
            // shift right from the insertion point, take the new entry at it
            if (self_out.key_after || !valid_reg)
            begin
                if (left.key_after)
                    data_next = left.data;
                else
                    data_next = cmd.new_entry;
                valid_next = valid_reg || left.valid;
            end
        end
        else if (cmd.ext && !phase)
        begin
            // advance everything one place toward the head
            valid_next = is_last ? 1'b0 : right.valid;
            data_next  = right.data;
        end
        else if (cmd.rec)
        begin
            if (!phase)
                mark_next = kill;
            else if (mark_reg)
                valid_next = 1'b0;
            else if (!valid_reg && right.valid && !right.kill && !is_last)
            begin
                // compaction bubble: pull from right while a hole sits here
                data_next  = right.data;
                valid_next = 1'b1;
            end
            else if (valid_reg && !left.valid && !left.kill)
                // entry moves into the hole on the left
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end
endmodule
`default_nettype wire

>>> rtl/sorted_event_queue.sv
// Insert, extract, queries and unused kinds: the beat is registered into S_RUN, the cells
// move there, and the result is registered into S_OUT. Recover: S_RUN marks, S_COMPACT removes
// the marked entries and compacts until the row is packed; compaction shifts each entry one place per cycle.
// One operation at a time; in_stall holds the next beat off until the result beat is
// taken, and a stall on the result holds the block.
// Reset: rst_n clears valid bits and count and sets thresholds (20, 5); payload is not reset.
`default_nettype none
module sorted_event_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [15:0] tag,
    input  wire logic [31:0] done_cycle,
    input  wire logic [31:0] sequence_req,
    input  wire logic [2:0]  thread_id,
    input  wire logic        is_load,
    input  wire logic        speculative,
    input  wire logic [31:0] issue_cycle,
    input  wire logic [31:0] now_cycle,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic             found,
    output logic [15:0]      out_tag,
    output logic [31:0]      out_done_cycle,
    output logic [31:0]      out_sequence,
    output logic [2:0]       out_thread,
    output logic [5:0]       removed_count,
    output logic [5:0]       occupancy,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import seq_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_COMPACT, S_OUT} state_t;

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [2:0]  kind_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] removed_reg;
    logic [15:0] long_reg, miss_reg;
    cell_out_t   cells [Depth];
    cell_out_t   idle_cell;
    cell_out_t   head_cell;
    logic        phase;
    logic        head_take;
    logic [Depth-1:0] hits, kills, holes;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign idle_cell = '0;
    // left of the head: a valid neighbor with a smaller key that never moves
    always_comb
    begin
        head_cell       = '0;
        head_cell.valid = 1'b1;
    end
    // phase 0: insert/extract moves and recover marking; phase 1: recover compaction sweep
    assign phase = (state_reg == S_COMPACT);
    assign head_take = (kind == KIND_EXTRACT) && (count_reg != '0);

    genvar g;
    generate
        for (g = 0; g < Depth; g++)
        begin : g_cell
            seq_cell u_cell (
                .clk(clk), .rst_n(rst_n),
                .cmd(cmd_reg),
                .phase(phase),
                .is_last(g == Depth - 1),
                .left(g == 0 ? head_cell : cells[(g == 0) ? 0 : g - 1]),
                .right(g == Depth - 1 ? idle_cell : cells[(g == Depth - 1) ? g : g + 1]),
                .self_out(cells[g])
            );
            assign hits[g]  = cells[g].hit;
            assign kills[g] = cells[g].kill;
            assign holes[g] = !cells[g].valid;
        end
    endgenerate

    // A hole below a valid entry means the row is not yet packed.
    function automatic logic compact_needed(input logic [Depth-1:0] h);
        logic seen;
        logic need;
        seen = 1'b0;
        need = 1'b0;
        for (int i = 0; i < Depth; i++)
        begin
            if (!h[i] && seen) need = 1'b1;
            if (h[i]) seen = 1'b1;
        end
        return need;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_valid   <= 1'b0;
            count_reg   <= '0;
            removed_reg <= '0;
            long_reg    <= 16'd20;
            miss_reg    <= 16'd5;
            cmd_reg     <= '0;
            kind_reg    <= '0;
            status <= '0; found <= 1'b0; out_tag <= '0; out_done_cycle <= '0;
            out_sequence <= '0; out_thread <= '0; removed_count <= '0; occupancy <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_LONG_WAIT) long_reg <= cfg_data;
                else if (cfg_index == REG_MISS_WAIT) miss_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg <= kind;
                        cmd_reg.ins <= (kind == KIND_INSERT) && (count_reg != Depth[CntW-1:0]);
                        cmd_reg.ext <= head_take;
                        cmd_reg.rec <= (kind == KIND_RECOVER);
                        cmd_reg.qry <= 1'b0;
                        cmd_reg.loads_only <= (kind == KIND_MISS);
                        cmd_reg.thread <= thread_id;
                        cmd_reg.now_cycle <= now_cycle;
                        cmd_reg.limit <= (kind == KIND_MISS) ? miss_reg : long_reg;
                        cmd_reg.new_entry <= '{tag, done_cycle, sequence_req, issue_cycle,
                                               thread_id, is_load, speculative};
                        found <= 1'b0;
                        removed_count <= '0;
                        if (kind == KIND_INSERT && count_reg == Depth[CntW-1:0])
                            status <= ST_FULL;
                        else if (kind == KIND_EXTRACT && count_reg == '0)
                            status <= ST_EMPTY;
                        else
                            status <= ST_DONE;
                        // capture the head before the row advances
                        out_tag        <= head_take ? cells[0].data.tag : '0;
                        out_done_cycle <= head_take ? cells[0].data.done_cycle : '0;
                        out_sequence   <= head_take ? cells[0].data.sequence_num : '0;
                        out_thread     <= head_take ? cells[0].data.thread : '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    // cells move this cycle; queries read the stable row
                    if (kind_reg == KIND_LONGWAIT || kind_reg == KIND_MISS)
                        found <= |hits;
                    if (cmd_reg.ins) count_reg <= count_reg + 1'b1;
                    if (cmd_reg.ext) count_reg <= count_reg - 1'b1;
                    cmd_reg.ins <= 1'b0;
                    cmd_reg.ext <= 1'b0;
                    if (cmd_reg.rec)
                    begin
                        state_reg <= S_COMPACT;
                    end
                    else
                    begin
                        occupancy <= count_reg + (cmd_reg.ins ? 1'b1 : 1'b0)
                                     - (cmd_reg.ext ? 1'b1 : 1'b0);
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_COMPACT:
                begin
                    if (kills == '0 && !compact_needed(holes))
                    begin
                        cmd_reg.rec <= 1'b0;
                        removed_count <= removed_reg;
                        count_reg <= count_reg - removed_reg;
                        occupancy <= count_reg - removed_reg;
                        removed_reg <= '0;
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        removed_reg <= removed_reg + CntW'($countones(kills));
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Depth[CntW-1:0]) else $error("count overflow");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_RUN || state_reg == S_COMPACT))
        else $error("result without work");
`endif
endmodule
`default_nettype wire
